/* rtl/rbscf_pkg.sv */
`default_nettype none
package rbscf_pkg;

   localparam int LEAVES     = 1024;
   localparam int LOG_LEAVES = 10;
   localparam int IDX_W      = 10;
   localparam int CMD_W      = 3;
   localparam int ONES_W     = 11;
   localparam int NODE_AW    = 11;
   localparam int NODE_DEPTH = 2 * LEAVES;
   localparam int BOUND_W    = 12;
   localparam int LVL_W      = 4;

   typedef enum logic [1:0] {
      PEND_NONE,
      PEND_SET,
      PEND_CLEAR,
      PEND_FLIP
   } pend_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD,
      CMD_SET,
      CMD_CLEAR,
      CMD_FLIP,
      CMD_COUNT
   } cmd_type;

   typedef struct packed {
      pend_type            pend;
      logic [ONES_W-1:0]   ones;
   } node_type;

   localparam int NODE_W = $bits(node_type);

   typedef struct packed {
      logic              count_only;
      pend_type          op;
      logic [IDX_W-1:0]  first;
      logic [IDX_W-1:0]  last;
   } walk_cmd_type;

   typedef struct packed {
      logic              idle;
      logic              done;
      logic [ONES_W-1:0] count;
   } walk_stat_type;

   // apply a set, clear or invert to a node covering len positions
   function automatic node_type apply_op(node_type n, logic [ONES_W-1:0] len, pend_type op);
      node_type r;
      r = n;
      case (op)
         PEND_SET: begin
            r.ones = len;
            r.pend = PEND_SET;
         end
         PEND_CLEAR: begin
            r.ones = '0;
            r.pend = PEND_CLEAR;
         end
         PEND_FLIP: begin
            r.ones = len - n.ones;
            case (n.pend)
               PEND_NONE:  r.pend = PEND_FLIP;
               PEND_SET:   r.pend = PEND_CLEAR;
               PEND_CLEAR: r.pend = PEND_SET;
               default:    r.pend = PEND_NONE;
            endcase
         end
         default: r = n;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/rbscf_if.sv */
`default_nettype none
interface rbscf_req_if;
   import rbscf_pkg::*;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [IDX_W-1:0]    first_index;
   logic [IDX_W-1:0]    last_index;
   logic                bit_value;
   modport source (output valid, command, first_index, last_index, bit_value, input ready);
   modport sink   (input valid, command, first_index, last_index, bit_value, output ready);
endinterface

interface rbscf_rsp_if;
   import rbscf_pkg::*;
   logic                valid;
   logic                ready;
   logic [ONES_W-1:0]   ones_count;
   logic                range_error;
   modport source (output valid, ones_count, range_error, input ready);
   modport sink   (input valid, ones_count, range_error, output ready);
endinterface

interface rbscf_csr_if;
   import rbscf_pkg::*;
   logic                valid;
   logic                ready;
   logic [ONES_W-1:0]   data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

/* rtl/rbscf_ram.sv */
`default_nettype none
module rbscf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* rtl/rbscf_walk.sv */
`default_nettype none
module rbscf_walk (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  rbscf_pkg::walk_cmd_type cmd,
   input  logic                    out_free,
   output rbscf_pkg::walk_stat_type stat
);
   import rbscf_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_PUSH_SEL,
      S_PUSH_CHK,
      S_PUSH_LC,
      S_PUSH_RC,
      S_LOOP,
      S_NODE,
      S_UP_SEL,
      S_UP_LC,
      S_UP_WR,
      S_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [NODE_AW-1:0]  clr_ff, clr_in;
   logic [LVL_W-1:0]    lvl_ff, lvl_in;
   logic                side_ff, side_in;
   logic [NODE_AW-1:0]  l0_ff, l0_in;
   logic [BOUND_W-1:0]  r0_ff, r0_in;
   logic [BOUND_W-1:0]  l_ff, l_in;
   logic [BOUND_W-1:0]  r_ff, r_in;
   logic [NODE_AW-1:0]  node_ff, node_in;
   pend_type            pend_ff, pend_in;
   logic [ONES_W-1:0]   ones_ff, ones_in;
   logic [ONES_W-1:0]   sum_ff, sum_in;
   pend_type            op_ff, op_in;
   logic                cnt_ff, cnt_in;

   logic                wr_en;
   logic [NODE_AW-1:0]  wr_addr;
   node_type            wr_node;
   logic [NODE_AW-1:0]  rd_addr;
   logic [NODE_W-1:0]   rd_raw;
   node_type            rd_node;

   logic [BOUND_W-1:0]  low_mask;
   logic [BOUND_W-1:0]  r0_m1;
   logic                cand_ok;
   logic [NODE_AW-1:0]  cand_node;
   logic [NODE_AW-1:0]  child_l;
   logic [NODE_AW-1:0]  child_r;
   logic [ONES_W-1:0]   child_len;
   logic [ONES_W-1:0]   node_len;

   function automatic logic [NODE_AW-1:0] r0_m1_loop(logic [BOUND_W-1:0] r);
      logic [BOUND_W-1:0] t;
      t = r - BOUND_W'(1);
      return t[NODE_AW-1:0];
   endfunction

   rbscf_ram #(
      .WIDTH(NODE_W),
      .DEPTH(NODE_DEPTH)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_node),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_node   = node_type'(rd_raw);
   assign low_mask  = ~({BOUND_W{1'b1}} << lvl_ff);
   assign r0_m1     = r0_ff - BOUND_W'(1);
   assign cand_ok   = side_ff ? ((r0_ff & low_mask) != '0)
                              : (({1'b0, l0_ff} & low_mask) != '0);
   assign cand_node = side_ff ? NODE_AW'(r0_m1 >> lvl_ff) : (l0_ff >> lvl_ff);
   assign child_l   = {node_ff[NODE_AW-2:0], 1'b0};
   assign child_r   = {node_ff[NODE_AW-2:0], 1'b1};
   assign child_len = ONES_W'(1) << (lvl_ff - LVL_W'(1));
   assign node_len  = ONES_W'(1) << lvl_ff;

   assign stat.idle  = (state_ff == S_IDLE);
   assign stat.done  = (state_ff == S_DONE) && out_free;
   assign stat.count = sum_ff;

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      lvl_in   = lvl_ff;
      side_in  = side_ff;
      l0_in    = l0_ff;
      r0_in    = r0_ff;
      l_in     = l_ff;
      r_in     = r_ff;
      node_in  = node_ff;
      pend_in  = pend_ff;
      ones_in  = ones_ff;
      sum_in   = sum_ff;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      wr_en    = 1'b0;
      wr_addr  = node_ff;
      wr_node  = rd_node;
      rd_addr  = cand_node;
      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_node = '{pend: PEND_NONE, ones: '0};
            clr_in  = clr_ff + NODE_AW'(1);
            if (clr_ff == {NODE_AW{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               l0_in    = NODE_AW'(LEAVES) + NODE_AW'(cmd.first);
               r0_in    = BOUND_W'(LEAVES) + BOUND_W'(cmd.last) + BOUND_W'(1);
               op_in    = cmd.op;
               cnt_in   = cmd.count_only;
               sum_in   = '0;
               lvl_in   = LVL_W'(LOG_LEAVES);
               side_in  = 1'b0;
               state_in = S_PUSH_SEL;
            end
         end
         S_PUSH_SEL: begin
            if (cand_ok) begin
               node_in  = cand_node;
               state_in = S_PUSH_CHK;
            end else begin
               side_in = ~side_ff;
               if (side_ff) begin
                  if (lvl_ff == LVL_W'(1)) begin
                     lvl_in   = '0;
                     l_in     = {1'b0, l0_ff};
                     r_in     = r0_ff;
                     state_in = S_LOOP;
                  end else begin
                     lvl_in = lvl_ff - LVL_W'(1);
                  end
               end
            end
         end
         S_PUSH_CHK: begin
            if (rd_node.pend == PEND_NONE) begin
               state_in = S_PUSH_SEL;
               side_in  = ~side_ff;
               if (side_ff) begin
                  if (lvl_ff == LVL_W'(1)) begin
                     lvl_in   = '0;
                     l_in     = {1'b0, l0_ff};
                     r_in     = r0_ff;
                     state_in = S_LOOP;
                  end else begin
                     lvl_in = lvl_ff - LVL_W'(1);
                  end
               end
            end else begin
               pend_in  = rd_node.pend;
               wr_en    = 1'b1;
               wr_addr  = node_ff;
               wr_node  = '{pend: PEND_NONE, ones: rd_node.ones};
               rd_addr  = child_l;
               state_in = S_PUSH_LC;
            end
         end
         S_PUSH_LC: begin
            wr_en    = 1'b1;
            wr_addr  = child_l;
            wr_node  = apply_op(rd_node, child_len, pend_ff);
            rd_addr  = child_r;
            state_in = S_PUSH_RC;
         end
         S_PUSH_RC: begin
            wr_en    = 1'b1;
            wr_addr  = child_r;
            wr_node  = apply_op(rd_node, child_len, pend_ff);
            state_in = S_PUSH_SEL;
            side_in  = ~side_ff;
            if (side_ff) begin
               if (lvl_ff == LVL_W'(1)) begin
                  lvl_in   = '0;
                  l_in     = {1'b0, l0_ff};
                  r_in     = r0_ff;
                  state_in = S_LOOP;
               end else begin
                  lvl_in = lvl_ff - LVL_W'(1);
               end
            end
         end
         S_LOOP: begin
            if (l_ff >= r_ff) begin
               lvl_in   = LVL_W'(1);
               side_in  = 1'b0;
               state_in = cnt_ff ? S_DONE : S_UP_SEL;
            end else if (l_ff[0]) begin
               rd_addr  = l_ff[NODE_AW-1:0];
               node_in  = l_ff[NODE_AW-1:0];
               l_in     = l_ff + BOUND_W'(1);
               state_in = S_NODE;
            end else if (r_ff[0]) begin
               rd_addr  = r0_m1_loop(r_ff);
               node_in  = r0_m1_loop(r_ff);
               r_in     = r_ff - BOUND_W'(1);
               state_in = S_NODE;
            end else begin
               l_in   = l_ff >> 1;
               r_in   = r_ff >> 1;
               lvl_in = lvl_ff + LVL_W'(1);
            end
         end
         S_NODE: begin
            if (cnt_ff) begin
               sum_in = sum_ff + rd_node.ones;
            end else begin
               wr_en   = 1'b1;
               wr_addr = node_ff;
               wr_node = apply_op(rd_node, node_len, op_ff);
            end
            state_in = S_LOOP;
         end
         S_UP_SEL: begin
            if (cand_ok) begin
               node_in  = cand_node;
               rd_addr  = {cand_node[NODE_AW-2:0], 1'b0};
               state_in = S_UP_LC;
            end else begin
               side_in = ~side_ff;
               if (side_ff) begin
                  if (lvl_ff == LVL_W'(LOG_LEAVES)) begin
                     state_in = S_DONE;
                  end else begin
                     lvl_in = lvl_ff + LVL_W'(1);
                  end
               end
            end
         end
         S_UP_LC: begin
            ones_in  = rd_node.ones;
            rd_addr  = child_r;
            state_in = S_UP_WR;
         end
         S_UP_WR: begin
            wr_en    = 1'b1;
            wr_addr  = node_ff;
            wr_node  = '{pend: PEND_NONE, ones: ones_ff + rd_node.ones};
            state_in = S_UP_SEL;
            side_in  = ~side_ff;
            if (side_ff) begin
               if (lvl_ff == LVL_W'(LOG_LEAVES)) begin
                  state_in = S_DONE;
               end else begin
                  lvl_in = lvl_ff + LVL_W'(1);
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      lvl_ff  <= lvl_in;
      side_ff <= side_in;
      l0_ff   <= l0_in;
      r0_ff   <= r0_in;
      l_ff    <= l_in;
      r_ff    <= r_in;
      node_ff <= node_in;
      pend_ff <= pend_in;
      ones_ff <= ones_in;
      sum_ff  <= sum_in;
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
   end

`ifndef SYNTHESIS
   a_no_root_slot: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff != S_CLEAR) |-> (wr_addr != '0))
      else $error("write to unused node slot");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> stat.idle)
      else $error("command started while walk busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      stat.done |=> stat.idle)
      else $error("walk not idle after result");
   a_loop_level: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOP) |-> (lvl_ff <= LVL_W'(LOG_LEAVES + 1)))
      else $error("loop level beyond root");
`endif
endmodule
`default_nettype wire

/* rtl/range_bit_set_clear_flip_count_core.sv */
`default_nettype none
// A rejected or unknown command is replied to in the cycle after acceptance; a tree
//   command is paced by the single read port of the node RAM, which reads each pushed
//   node and its children, each node of the cover, and both children of each parent.
// Throughput: one command at a time; the next is taken once the walk is idle and the reply slot is free.
// Reset: synchronous; afterwards a clearing pass zeroes every slot of the node RAM,
//   during which no command is accepted. used_length resets to 1024.
module range_bit_set_clear_flip_count_core (
   input  logic              clock,
   input  logic              reset,
   rbscf_req_if.sink         req_bus,
   rbscf_rsp_if.source       rsp_bus,
   rbscf_csr_if.sink         csr_bus
);
   import rbscf_pkg::*;

   logic [ONES_W-1:0] used_length_ff, used_length_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ONES_W-1:0] rsp_count_ff, rsp_count_in;
   logic              rsp_error_ff, rsp_error_in;

   walk_cmd_type      wcmd;
   walk_stat_type     wstat;
   logic              out_free;
   logic              accept;
   logic              go;
   logic              err;
   logic              first_bad;
   logic              range_bad;

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = wstat.idle && out_free;
   assign accept        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign first_bad = {1'b0, req_bus.first_index} >= used_length_ff;
   assign range_bad = (req_bus.first_index > req_bus.last_index)
                   || ({1'b0, req_bus.last_index} >= used_length_ff);

   always_comb begin
      wcmd.count_only = 1'b0;
      wcmd.op         = PEND_NONE;
      wcmd.first      = req_bus.first_index;
      wcmd.last       = req_bus.last_index;
      err             = 1'b0;
      go              = 1'b0;
      case (cmd_type'(req_bus.command))
         CMD_LOAD: begin
            // a load is a one-position set or clear
            wcmd.op   = req_bus.bit_value ? PEND_SET : PEND_CLEAR;
            wcmd.last = req_bus.first_index;
            err       = first_bad;
            go        = !first_bad;
         end
         CMD_SET: begin
            wcmd.op = PEND_SET;
            err     = range_bad;
            go      = !range_bad;
         end
         CMD_CLEAR: begin
            wcmd.op = PEND_CLEAR;
            err     = range_bad;
            go      = !range_bad;
         end
         CMD_FLIP: begin
            wcmd.op = PEND_FLIP;
            err     = range_bad;
            go      = !range_bad;
         end
         CMD_COUNT: begin
            wcmd.count_only = 1'b1;
            err             = range_bad;
            go              = !range_bad;
         end
         default: begin
            err = 1'b0;
            go  = 1'b0;
         end
      endcase
   end

   rbscf_walk u_walk (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && go),
      .cmd      (wcmd),
      .out_free (out_free),
      .stat     (wstat)
   );

   always_comb begin
      used_length_in = used_length_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         used_length_in = csr_bus.data;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_error_in = rsp_error_ff;
      if (accept && !go) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = '0;
         rsp_error_in = err;
      end else if (wstat.done) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = wstat.count;
         rsp_error_in = 1'b0;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_length_ff <= ONES_W'(LEAVES);
         rsp_valid_ff   <= 1'b0;
      end else begin
         used_length_ff <= used_length_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_count_ff <= rsp_count_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.ones_count  = rsp_count_ff;
   assign rsp_bus.range_error = rsp_error_ff;

`ifndef SYNTHESIS
   a_one_source: assert property (@(posedge clock) disable iff (reset)
      !(accept && !go && wstat.done))
      else $error("direct reply collides with walk result");
   a_reply_after_reject: assert property (@(posedge clock) disable iff (reset)
      (accept && !go) |=> (rsp_valid_ff && rsp_count_ff == '0))
      else $error("rejected command gave no empty reply");
   a_done_when_free: assert property (@(posedge clock) disable iff (reset)
      wstat.done |-> out_free)
      else $error("result overwrote a waiting beat");
`endif
endmodule
`default_nettype wire
